// File: hw/rtl/rtt_fcm_pkg.sv
// shared types and constants for the rtt flow control mode block
`default_nettype none
package rtt_fcm_pkg;

	localparam int TimerW  = 24;
	localparam int WindowW = 24;
	localparam int CmpW    = (TimerW > WindowW) ? TimerW : WindowW;
	localparam int AddrW   = 5;
	localparam int DataW   = 32;

	localparam logic [4:0] GoodRate = 5'd30;
	localparam logic [4:0] BadRate  = 5'd10;

	localparam logic [15:0] RttThrRst   = 16'd250;
	localparam logic [11:0] TickLenRst  = 12'd34;
	localparam logic [15:0] InitPenRst  = 16'd4096;
	localparam logic [15:0] PenMaxRst   = 16'd61440;
	localparam logic [15:0] PenMinRst   = 16'd1024;
	localparam logic [WindowW-1:0] WindowRst = WindowW'(10240);

	typedef enum logic [2:0] {
		REG_RTT_THR  = 3'd0,
		REG_TICK_LEN = 3'd1,
		REG_INIT_PEN = 3'd2,
		REG_PEN_MAX  = 3'd3,
		REG_PEN_MIN  = 3'd4,
		REG_WINDOW   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_DROP   = 2'd1,
		EV_UP     = 2'd2,
		EV_REDUCE = 2'd3
	} mode_event_t;

	typedef struct packed {
		logic [15:0]        rtt_threshold_ms;
		logic [11:0]        tick_length;
		logic [15:0]        initial_penalty;
		logic [15:0]        penalty_max;
		logic [15:0]        penalty_min;
		logic [WindowW-1:0] stable_window;
	} cfg_t;

	typedef struct packed {
		logic        good_mode;
		logic [4:0]  send_rate;
		logic [15:0] penalty_now;
		mode_event_t mode_event;
	} res_t;

endpackage
`default_nettype wire

// File: hw/rtl/rtt_fcm_cfg.sv
// configuration register file behind the apb-style port
`default_nettype none
module rtt_fcm_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rtt_fcm_pkg::AddrW-1:0] paddr,
	input  wire logic [rtt_fcm_pkg::DataW-1:0] pwdata,
	output logic      [rtt_fcm_pkg::DataW-1:0] prdata,
	output logic                            pready,
	output rtt_fcm_pkg::cfg_t               cfg
);
	import rtt_fcm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rtt_threshold_ms <= RttThrRst;
			cfg_q.tick_length      <= TickLenRst;
			cfg_q.initial_penalty  <= InitPenRst;
			cfg_q.penalty_max      <= PenMaxRst;
			cfg_q.penalty_min      <= PenMinRst;
			cfg_q.stable_window    <= WindowRst;
		end else if (wr_en) begin
			case (idx)
				REG_RTT_THR:  cfg_q.rtt_threshold_ms <= pwdata[15:0];
				REG_TICK_LEN: cfg_q.tick_length      <= pwdata[11:0];
				REG_INIT_PEN: cfg_q.initial_penalty  <= pwdata[15:0];
				REG_PEN_MAX:  cfg_q.penalty_max      <= pwdata[15:0];
				REG_PEN_MIN:  cfg_q.penalty_min      <= pwdata[15:0];
				REG_WINDOW:   cfg_q.stable_window    <= pwdata[WindowW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RTT_THR:  prdata = DataW'(cfg_q.rtt_threshold_ms);
			REG_TICK_LEN: prdata = DataW'(cfg_q.tick_length);
			REG_INIT_PEN: prdata = DataW'(cfg_q.initial_penalty);
			REG_PEN_MAX:  prdata = DataW'(cfg_q.penalty_max);
			REG_PEN_MIN:  prdata = DataW'(cfg_q.penalty_min);
			REG_WINDOW:   prdata = DataW'(cfg_q.stable_window);
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/rtt_fcm_upd.sv
// mode, penalty and timer state with the per-tick update logic
`default_nettype none
module rtt_fcm_upd (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [15:0]       rtt_ms,
	input  wire logic              clear_state,
	input  rtt_fcm_pkg::cfg_t      cfg,
	output rtt_fcm_pkg::res_t      res
);
	import rtt_fcm_pkg::*;

	logic              mode_q;
	logic [15:0]       pen_q;
	logic [TimerW-1:0] good_q;
	logic [TimerW-1:0] red_q;

	logic              mode_d;
	logic [15:0]       pen_d;
	logic [TimerW-1:0] good_d;
	logic [TimerW-1:0] red_d;
	mode_event_t       ev;

	logic              bad;
	logic [TimerW:0]   good_sum;
	logic [TimerW:0]   red_sum;
	logic [TimerW-1:0] good_inc;
	logic [TimerW-1:0] red_inc;
	logic [TimerW-1:0] good_bad;
	logic [CmpW-1:0]   win_x;
	logic [16:0]       pen_dbl;
	logic [15:0]       pen_half;

	assign bad      = rtt_ms > cfg.rtt_threshold_ms;
	assign good_sum = {1'b0, good_q} + (TimerW+1)'(cfg.tick_length);
	assign red_sum  = {1'b0, red_q} + (TimerW+1)'(cfg.tick_length);
	// timers saturate at all ones
	assign good_inc = good_sum[TimerW] ? '1 : good_sum[TimerW-1:0];
	assign red_inc  = red_sum[TimerW] ? '1 : red_sum[TimerW-1:0];
	assign good_bad = bad ? '0 : good_inc;
	assign win_x    = CmpW'(cfg.stable_window);
	assign pen_dbl  = {pen_q, 1'b0};
	assign pen_half = {1'b0, pen_q[15:1]};

	always_comb begin
		mode_d = mode_q;
		pen_d  = pen_q;
		good_d = good_q;
		red_d  = red_q;
		ev     = EV_NONE;
		if (clear_state) begin
			mode_d = 1'b0;
			pen_d  = cfg.initial_penalty;
			good_d = '0;
			red_d  = '0;
		end else if (mode_q) begin
			if (bad) begin
				mode_d = 1'b0;
				if (CmpW'(good_q) < win_x && pen_q < cfg.penalty_max) begin
					pen_d = (pen_dbl > {1'b0, cfg.penalty_max}) ? cfg.penalty_max
						: pen_dbl[15:0];
				end
				good_d = '0;
				red_d  = '0;
				ev     = EV_DROP;
			end else begin
				good_d = good_inc;
				red_d  = red_inc;
				if (CmpW'(red_inc) > win_x && pen_q > cfg.penalty_min) begin
					pen_d = (pen_half < cfg.penalty_min) ? cfg.penalty_min : pen_half;
					red_d = '0;
					ev    = EV_REDUCE;
				end
			end
		end else begin
			good_d = good_bad;
			if (CmpW'(good_bad) > CmpW'(pen_q)) begin
				good_d = '0;
				red_d  = '0;
				mode_d = 1'b1;
				ev     = EV_UP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pen_q  <= InitPenRst;
			good_q <= '0;
			red_q  <= '0;
		end else if (en) begin
			mode_q <= mode_d;
			pen_q  <= pen_d;
			good_q <= good_d;
			red_q  <= red_d;
		end
	end

	assign res.good_mode   = mode_d;
	assign res.send_rate   = mode_d ? GoodRate : BadRate;
	assign res.penalty_now = pen_d;
	assign res.mode_event  = ev;

endmodule
`default_nettype wire

// File: hw/rtl/rtt_flow_control_mode_top.sv
// rtt flow control mode: good/bad send mode driven by measured round-trip time
//
// input channel: in_valid / in_stall with rtt_ms and clear_state, one update
// tick per request. output channel: out_valid / out_stall with good_mode,
// send_rate, penalty_now and mode_event, one result per tick, in order.
// configuration: apb-style port, registers at byte addresses 0x00..0x14
// (threshold, tick length, initial penalty, penalty max, penalty min,
// stable window); write only while no tick is in flight.
// a taken tick is held in the input register, then its state update is written
// together with the result register. throughput: one tick per cycle while out_stall
// is low, set by the single state update between the input register and the result
// register.
// reset: arst_n clears both stages, loads the register reset values and puts
// the block in bad mode with the initial penalty; asynchronous, no clearing sequence.
// a held result stays stable while out_stall is high; the input register
// still takes one more tick, after which in_stall rises until the result
// is taken.
`default_nettype none
module rtt_flow_control_mode_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [15:0]                   rtt_ms,
	input  wire logic                          clear_state,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               good_mode,
	output logic      [4:0]                    send_rate,
	output logic      [15:0]                   penalty_now,
	output logic      [1:0]                    mode_event,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rtt_fcm_pkg::AddrW-1:0] paddr,
	input  wire logic [rtt_fcm_pkg::DataW-1:0] pwdata,
	output logic      [rtt_fcm_pkg::DataW-1:0] prdata,
	output logic                               pready
);
	import rtt_fcm_pkg::*;

	cfg_t        cfg;
	res_t        res;
	res_t        res_q;
	logic        valid_s1;
	logic [15:0] rtt_s1;
	logic        clr_s1;
	logic        out_valid_q;
	logic        advance;
	logic        take;

	rtt_fcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtt_fcm_upd u_upd (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.rtt_ms      (rtt_s1),
		.clear_state (clr_s1),
		.cfg         (cfg),
		.res         (res)
	);

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rtt_s1 <= rtt_ms;
			clr_s1 <= clear_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign good_mode   = res_q.good_mode;
	assign send_rate   = res_q.send_rate;
	assign penalty_now = res_q.penalty_now;
	assign mode_event  = res_q.mode_event;

endmodule
`default_nettype wire
